// ===== rtl/gbro_pkg.sv =====
// ----------------------------------------------------------------------------
// gbro_pkg
// Shared types and constants for the glyph byte raster op block.
// ----------------------------------------------------------------------------
package gbro_pkg;

    localparam int LANES      = 8;
    localparam int LANE_BITS  = 8;   // bus slot per lane
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_COMBINE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS = 2'd2;

    typedef enum logic [1:0] {
        CM_REPLACE = 2'd0,
        CM_OR      = 2'd1,
        CM_XOR     = 2'd2,
        CM_AND     = 2'd3
    } t_combine;

    typedef struct packed {
        t_combine   combine_mode;
        logic       shade_enable;
        logic [1:0] write_suppress;
    } t_cfg;

    typedef struct packed {
        logic                 wen;
        logic [LANE_BITS-1:0] pixel;
    } t_lane_res;

    typedef struct packed {
        logic signed [13:0]         first_pixel_x;
        logic [12:0]                pixel_y;
        logic [LANES*LANE_BITS-1:0] new_pixels;
        logic [LANES-1:0]           write_enables;
    } t_result;

endpackage

// ===== rtl/gbro_if.sv =====
// ----------------------------------------------------------------------------
// gbro_if
// Channel interfaces: glyph byte input, pixel result output, register writes.
// ----------------------------------------------------------------------------
interface gbro_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  glyph_byte;
    logic [7:0]  row_index;
    logic [3:0]  bit_count;
    logic [9:0]  byte_bit_offset;
    logic [2:0]  lead_skip;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [63:0] old_pixels;
    logic [7:0]  pen_colour;
    logic [7:0]  paper_colour;

    modport source (
        output valid, glyph_byte, row_index, bit_count, byte_bit_offset, lead_skip,
               origin_x, origin_y, old_pixels, pen_colour, paper_colour,
        input  ready
    );
    modport sink (
        input  valid, glyph_byte, row_index, bit_count, byte_bit_offset, lead_skip,
               origin_x, origin_y, old_pixels, pen_colour, paper_colour,
        output ready
    );
endinterface

interface gbro_out_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] first_pixel_x;
    logic [12:0]        pixel_y;
    logic [63:0]        new_pixels;
    logic [7:0]         write_enables;

    modport source (
        output valid, first_pixel_x, pixel_y, new_pixels, write_enables,
        input  ready
    );
    modport sink (
        input  valid, first_pixel_x, pixel_y, new_pixels, write_enables,
        output ready
    );
endinterface

interface gbro_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/gbro_lane.sv =====
// ----------------------------------------------------------------------------
// gbro_lane
// One pixel lane: glyph bit to colour, raster op with the old pixel, strobe.
// ----------------------------------------------------------------------------
module gbro_lane #(
    parameter int LANE       = 0,
    parameter int PIXEL_BITS = 8
) (
    input  gbro_pkg::t_cfg      i_cfg,
    input  logic                i_glyph_bit,
    input  logic                i_row_lsb,
    input  logic [3:0]          i_bit_count,
    input  logic [9:0]          i_byte_bit_offset,
    input  logic [2:0]          i_lead_skip,
    input  logic [7:0]          i_pen_colour,
    input  logic [7:0]          i_paper_colour,
    input  logic [7:0]          i_old_pixel,
    output gbro_pkg::t_lane_res o_res
);
    import gbro_pkg::*;

    localparam logic [LANE_BITS:0]   PMASK_W = (
        (LANE_BITS+1)'(1) << PIXEL_BITS) - (LANE_BITS+1)'(1);
    localparam logic [LANE_BITS-1:0] PMASK   = PMASK_W[LANE_BITS-1:0];
    localparam logic [3:0]           LANE_X  = 4'(LANE);
    localparam logic [10:0]          LANE_X11 = 11'(LANE);

    logic                 in_glyph;
    logic                 bit_set;
    logic                 suppressed;
    logic [LANE_BITS-1:0] colour;
    logic [LANE_BITS-1:0] prev;
    logic [LANE_BITS-1:0] val;

    // lane lies inside the glyph and not left of its first drawn column
    assign in_glyph = (LANE_X < i_bit_count) &&
                      (({1'b0, i_byte_bit_offset} + LANE_X11) >= {8'd0, i_lead_skip});

    // checkerboard: drop bits where column and row parity agree
    assign bit_set = i_glyph_bit && !(i_cfg.shade_enable && (LANE_X[0] == i_row_lsb));

    assign suppressed = bit_set ? i_cfg.write_suppress[0] : i_cfg.write_suppress[1];
    assign colour     = (bit_set ? i_pen_colour : i_paper_colour) & PMASK;
    assign prev       = i_old_pixel & PMASK;

    always_comb begin
        case (i_cfg.combine_mode)
            CM_OR:   val = prev | colour;
            CM_XOR:  val = prev ^ colour;
            CM_AND:  val = prev & colour;
            default: val = colour;
        endcase
    end

    assign o_res.wen   = in_glyph && !suppressed;
    assign o_res.pixel = o_res.wen ? val : i_old_pixel;

endmodule

// ===== rtl/gbro_merge.sv =====
// ----------------------------------------------------------------------------
// gbro_merge
// Gathers the lane results into one result word and buffers it in an
// output register backed by a skid register.
// ----------------------------------------------------------------------------
module gbro_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_fire,
    output logic                o_in_ready,
    input  gbro_pkg::t_lane_res i_lanes [gbro_pkg::LANES],
    input  logic signed [13:0]  i_first_pixel_x,
    input  logic [12:0]         i_pixel_y,
    output logic                o_valid,
    input  logic                i_ready,
    output gbro_pkg::t_result   o_result
);
    import gbro_pkg::*;

    t_result merged;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    out_fire;

    always_comb begin
        merged.first_pixel_x = i_first_pixel_x;
        merged.pixel_y       = i_pixel_y;
        for (int x = 0; x < LANES; x++) begin
            merged.new_pixels[x*LANE_BITS +: LANE_BITS] = i_lanes[x].pixel;
            merged.write_enables[x]                     = i_lanes[x].wen;
        end
    end

    assign out_fire   = r_out_valid && i_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            // advance the skid entry, or drain
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= merged;
            end else begin
                r_skid <= merged;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule

// ===== rtl/glyph_byte_raster_op.sv =====
// ----------------------------------------------------------------------------
// glyph_byte_raster_op
// Expands one font byte into eight chunky pixels with a raster op.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one glyph row byte with its placement, the eight old pixels
//   and the two colours. o_out returns the lane 0 coordinates, the eight new
//   pixels and one write strobe per lane. i_cfg writes the combine mode
//   (index 0), shade enable (index 1) and write suppress mask (index 2);
//   writes to other indexes are ignored. i_cfg is always ready.
//   A transferred byte is registered in the output register, or in the skid
//   register if a stalled result waits. Eight lanes work on all bits in the
//   same cycle, so a byte can go in every cycle while i_in.ready is high.
//   When the receiver stalls, the waiting result holds in the output
//   register and one more byte is taken into a skid register; i_in.ready
//   drops only while that skid register is full.
//   Reset clears the registers to replace mode, no shading and no
//   suppression, and empties the output side.
// ----------------------------------------------------------------------------
module glyph_byte_raster_op #(
    parameter int PIXEL_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gbro_in_if.sink           i_in,
    gbro_out_if.source        o_out,
    gbro_cfg_if.sink          i_cfg
);
    import gbro_pkg::*;

    t_cfg               r_cfg;
    t_lane_res          lanes [LANES];
    t_result            result;
    logic               in_fire;
    logic signed [13:0] first_pixel_x;
    logic [12:0]        pixel_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.combine_mode   <= CM_REPLACE;
            r_cfg.shade_enable   <= 1'b0;
            r_cfg.write_suppress <= 2'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_COMBINE:  r_cfg.combine_mode   <= t_combine'(i_cfg.data);
                REG_SHADE:    r_cfg.shade_enable   <= i_cfg.data[0];
                REG_SUPPRESS: r_cfg.write_suppress <= i_cfg.data;
                default:      ;
            endcase
        end
    end

    assign in_fire = i_in.valid && i_in.ready;

    assign first_pixel_x = $signed(14'(i_in.origin_x) + 14'(i_in.byte_bit_offset)
                                   - 14'(i_in.lead_skip));
    assign pixel_y       = 13'(i_in.origin_y) + 13'(i_in.row_index);

    for (genvar x = 0; x < LANES; x++) begin : g_lane
        gbro_lane #(
            .LANE       (x),
            .PIXEL_BITS (PIXEL_BITS)
        ) u_lane (
            .i_cfg             (r_cfg),
            .i_glyph_bit       (i_in.glyph_byte[LANES-1-x]),
            .i_row_lsb         (i_in.row_index[0]),
            .i_bit_count       (i_in.bit_count),
            .i_byte_bit_offset (i_in.byte_bit_offset),
            .i_lead_skip       (i_in.lead_skip),
            .i_pen_colour      (i_in.pen_colour),
            .i_paper_colour    (i_in.paper_colour),
            .i_old_pixel       (i_in.old_pixels[x*LANE_BITS +: LANE_BITS]),
            .o_res             (lanes[x])
        );
    end

    gbro_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_fire       (in_fire),
        .o_in_ready      (i_in.ready),
        .i_lanes         (lanes),
        .i_first_pixel_x (first_pixel_x),
        .i_pixel_y       (pixel_y),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_result        (result)
    );

    assign o_out.first_pixel_x = result.first_pixel_x;
    assign o_out.pixel_y       = result.pixel_y;
    assign o_out.new_pixels    = result.new_pixels;
    assign o_out.write_enables = result.write_enables;

endmodule

// ===== rtl/gbro_checker.sv =====
// ----------------------------------------------------------------------------
// gbro_checker
// Port-level checks on the glyph byte raster op, bound to the top level.
// ----------------------------------------------------------------------------
module gbro_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_pixels,
    input logic [7:0]  i_out_enables
);

    // output side is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && $past(i_out_valid && !i_out_ready)))
        else $error("input stalled without a waiting result");

    // a transfer into an empty block shows up on the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> i_out_valid)
        else $error("result missing one cycle after transfer");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_pixels) && $stable(i_out_enables)))
        else $error("stalled result changed");

endmodule

bind glyph_byte_raster_op gbro_checker u_gbro_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_pixels  (o_out.new_pixels),
    .i_out_enables (o_out.write_enables)
);
